// ----- src/c3z_pkg.sv -----
// ============================================================================
// c3z_pkg
// Shared types and constants for the 3x3 zero-padded convolution stream.
// ============================================================================
package c3z_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned PSUM_W     = 34;
    localparam int unsigned SUM_W      = 35;
    localparam int unsigned ROW_W      = 16;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned KDIM       = 3;
    localparam int unsigned TAPS       = KDIM * KDIM;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFS_LOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFS_HIGH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_LAST   = 3'd4;

    // input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [ROW_W-1:0] ROW_MAX = 16'hFFFF;

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic                    frame_last;
    } out_beat_t;

    // per-beat control carried down the pipe
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       emit;
        logic                       last;
        logic                       at_top;
        logic                       at_bottom;
        logic                       at_left;
        logic                       at_right;
    } item_t;

    typedef logic [SAMPLE_W-1:0] word_t;
    typedef word_t [TAPS-1:0]    word_bank_t;

endpackage

// ----- src/c3z_ram.sv -----
// ============================================================================
// c3z_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
module c3z_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/c3z_ctrl.sv -----
// ============================================================================
// c3z_ctrl
// Configuration registers and the raster counters; tags each accepted beat.
// ============================================================================
module c3z_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [c3z_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [c3z_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                acc,
    input  c3z_pkg::in_beat_t                   s_data,
    output c3z_pkg::item_t                      item,
    output logic [CW-1:0]                       col,
    output c3z_pkg::word_bank_t                 coefs
);

    localparam logic [WW-1:0] W_RESET = WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
    localparam logic [WW-1:0] W_MAX   = WW'(MAX_WIDTH);

    logic [WW-1:0]                   w_reg;
    logic [c3z_pkg::ROW_W-1:0]       h_reg;
    c3z_pkg::word_bank_t             coef_reg;
    logic [CW-1:0]                   in_col_reg, in_col_next;
    logic [c3z_pkg::ROW_W-1:0]       in_row_reg, in_row_next;
    logic [CW-1:0]                   out_col_reg, out_col_next;
    logic [c3z_pkg::ROW_W-1:0]       out_row_reg, out_row_next;

    logic [10:0]                     wr_w;
    logic [WW-1:0]                   wr_w_eff;
    logic [CW-1:0]                   ic, oc;
    logic [WW-1:0]                   ic_inc, oc_inc;
    logic                            in_wrap, out_wrap;
    logic [c3z_pkg::ROW_W:0]         out_row_inc;
    logic                            emit, last, bottom, right;

    // width register holds the clamped value
    assign wr_w = cfg_wdata[10:0];
    always_comb begin
        if (wr_w == 11'd0) begin
            wr_w_eff = WW'(1);
        end else if (32'(wr_w) > 32'(MAX_WIDTH)) begin
            wr_w_eff = W_MAX;
        end else begin
            wr_w_eff = WW'(wr_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= W_RESET;
            h_reg    <= 16'd1;
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                c3z_pkg::REG_IMAGE_WIDTH: begin
                    w_reg <= wr_w_eff;
                end
                c3z_pkg::REG_IMAGE_HEIGHT: begin
                    h_reg <= (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
                end
                c3z_pkg::REG_COEFS_LOW: begin
                    for (int k = 0; k < 4; k++) begin
                        coef_reg[k] <= cfg_wdata[16*k +: 16];
                    end
                end
                c3z_pkg::REG_COEFS_HIGH: begin
                    for (int k = 0; k < 4; k++) begin
                        coef_reg[4+k] <= cfg_wdata[16*k +: 16];
                    end
                end
                c3z_pkg::REG_COEF_LAST: begin
                    coef_reg[8] <= cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // columns left over from a wider setting wrap before use
    assign ic = (WW'(in_col_reg) >= w_reg) ? '0 : in_col_reg;
    assign oc = (WW'(out_col_reg) >= w_reg) ? '0 : out_col_reg;

    assign ic_inc   = WW'(ic) + WW'(1);
    assign oc_inc   = WW'(oc) + WW'(1);
    assign in_wrap  = ic_inc >= w_reg;
    assign out_wrap = oc_inc >= w_reg;

    assign out_row_inc = {1'b0, out_row_reg} + 17'd1;
    assign bottom      = out_row_inc >= {1'b0, h_reg};
    assign right       = out_wrap;
    assign last        = bottom && right;

    assign emit = (in_row_reg >= 16'd2) || (in_row_reg == 16'd1 && ic != '0);

    always_comb begin
        in_col_next  = in_wrap ? '0 : ic_inc[CW-1:0];
        in_row_next  = (in_wrap && in_row_reg != c3z_pkg::ROW_MAX) ?
                       in_row_reg + 16'd1 : in_row_reg;
        out_col_next = oc;
        out_row_next = out_row_reg;
        if (emit) begin
            if (last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                out_col_next = out_wrap ? '0 : oc_inc[CW-1:0];
                if (out_wrap && out_row_reg != c3z_pkg::ROW_MAX) begin
                    out_row_next = out_row_inc[c3z_pkg::ROW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (acc) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_comb begin
        item.sample    = (s_data.opcode == c3z_pkg::OP_PIXEL && in_row_reg < h_reg) ?
                         s_data.sample : '0;
        item.emit      = emit;
        item.last      = last;
        item.at_top    = out_row_reg == '0;
        item.at_bottom = bottom;
        item.at_left   = oc == '0;
        item.at_right  = right;
    end

    assign col   = ic;
    assign coefs = coef_reg;

endmodule

// ----- src/c3z_line.sv -----
// ============================================================================
// c3z_line
// Line store read-modify-write and the 3x3 window.
// Both line rows share one RAM word {older, newer}; the write of one beat
// is forwarded to the read of the next when both hit the same column.
// ============================================================================
module c3z_line #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  acc,
    input  c3z_pkg::item_t        item_in,
    input  logic [CW-1:0]         col_in,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output c3z_pkg::item_t        item_out,
    output c3z_pkg::word_bank_t   window
);

    localparam int RW = 2 * c3z_pkg::SAMPLE_W;

    logic                  v1_reg, v2_reg;
    c3z_pkg::item_t        item1_reg, item2_reg;
    logic [CW-1:0]         col1_reg;
    logic                  fwd1_reg;
    logic [RW-1:0]         fwd_data_reg;
    c3z_pkg::word_bank_t   win_reg;

    logic                  en1, en2, wr_en;
    logic [RW-1:0]         rd_data, rd_eff, wr_data;
    c3z_pkg::word_t        older_eff, newer_eff;

    assign en2   = !v2_reg || !item2_reg.emit || out_ready;
    assign en1   = !v1_reg || en2;
    assign wr_en = v1_reg && en2;

    assign rd_eff    = fwd1_reg ? fwd_data_reg : rd_data;
    assign older_eff = rd_eff[RW-1:c3z_pkg::SAMPLE_W];
    assign newer_eff = rd_eff[c3z_pkg::SAMPLE_W-1:0];
    assign wr_data   = {newer_eff, item1_reg.sample};

    c3z_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (col1_reg),
        .wdata (wr_data),
        .re    (en1),
        .raddr (col_in),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= acc;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            item1_reg    <= item_in;
            col1_reg     <= col_in;
            fwd1_reg     <= wr_en && (col_in == col1_reg);
            fwd_data_reg <= wr_data;
        end
        if (en2) begin
            item2_reg <= item1_reg;
        end
    end

    // window: index 3*row + column, row 0 oldest line, column 0 leftmost
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (wr_en) begin
            for (int a = 0; a < 3; a++) begin
                win_reg[3*a]     <= win_reg[3*a + 1];
                win_reg[3*a + 1] <= win_reg[3*a + 2];
            end
            win_reg[2] <= older_eff;
            win_reg[5] <= newer_eff;
            win_reg[8] <= item1_reg.sample;
        end
    end

    assign in_ready  = en1;
    assign out_valid = v2_reg && item2_reg.emit;
    assign item_out  = item2_reg;
    assign window    = win_reg;

endmodule

// ----- src/c3z_mac.sv -----
// ============================================================================
// c3z_mac
// Masked products, two-level adder and the output register.
// ============================================================================
module c3z_mac (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  c3z_pkg::item_t        item,
    input  c3z_pkg::word_bank_t   window,
    input  c3z_pkg::word_bank_t   coefs,
    output logic                  m_valid,
    input  logic                  m_ready,
    output c3z_pkg::out_beat_t    m_data
);

    logic signed [c3z_pkg::PROD_W-1:0] prod     [c3z_pkg::TAPS];
    logic signed [c3z_pkg::PROD_W-1:0] prod_reg [c3z_pkg::TAPS];
    logic signed [c3z_pkg::PSUM_W-1:0] psum_reg [c3z_pkg::KDIM];
    logic                              v3_reg, v4_reg, m_valid_reg;
    logic                              last3_reg, last4_reg;
    c3z_pkg::out_beat_t                m_data_reg;
    logic                              en3, en4, en5;

    assign en5 = !m_valid_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;

    // kernel is flipped: tap k weights with entry 8-k
    for (genvar k = 0; k < c3z_pkg::TAPS; k++) begin : g_tap
        localparam int A = k / 3;
        localparam int B = k % 3;
        logic                              use_tap;
        logic signed [c3z_pkg::PROD_W-1:0] full_prod;
        assign use_tap = !(A == 0 && item.at_top) && !(A == 2 && item.at_bottom) &&
                         !(B == 0 && item.at_left) && !(B == 2 && item.at_right);
        assign full_prod = $signed(window[k]) * $signed(coefs[c3z_pkg::TAPS-1-k]);
        assign prod[k]   = use_tap ? full_prod : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en3) begin
                v3_reg <= in_valid;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int k = 0; k < c3z_pkg::TAPS; k++) begin
                prod_reg[k] <= prod[k];
            end
            last3_reg <= item.last;
        end
        if (en4) begin
            for (int a = 0; a < c3z_pkg::KDIM; a++) begin
                psum_reg[a] <= c3z_pkg::PSUM_W'(prod_reg[3*a])
                             + c3z_pkg::PSUM_W'(prod_reg[3*a + 1])
                             + c3z_pkg::PSUM_W'(prod_reg[3*a + 2]);
            end
            last4_reg <= last3_reg;
        end
        if (en5) begin
            m_data_reg.conv_sum   <= c3z_pkg::SUM_W'(psum_reg[0])
                                   + c3z_pkg::SUM_W'(psum_reg[1])
                                   + c3z_pkg::SUM_W'(psum_reg[2]);
            m_data_reg.frame_last <= last4_reg;
        end
    end

    assign in_ready = en3;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

endmodule

// ----- src/conv3x3_zero_padded_stream.sv -----
// ============================================================================
// conv3x3_zero_padded_stream
// Same-size 3x3 convolution (flipped kernel, zero padding) of a raster
// pixel stream, two line stores in one RAM, Q2.13 kernel, exact sums.
//
//   channel | ports                     | payload
//   --------+---------------------------+-----------------------------------
//   input   | s_valid s_ready s_data    | opcode, sample (signed 16)
//   output  | m_valid m_ready m_data    | conv_sum (signed 35), frame_last
//   config  | cfg_wr_en cfg_addr        | cfg_wdata (64), no read-back
//
// One beat per cycle sustained while the output is not stalled; an input
// beat's result, if it makes one, passes RAM read, window, multiply, two adds.
// Results lag the input stream by image_width+1 beats.
// Reset is synchronous and clears counters, window and pipe valids; no RAM
// clearing pass is needed. A stalled output backs up stage by stage, and
// s_ready falls only once every stage holds a beat.
// ============================================================================
module conv3x3_zero_padded_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [c3z_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [c3z_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  c3z_pkg::in_beat_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output c3z_pkg::out_beat_t               m_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                  acc;
    c3z_pkg::item_t        item_in, item_win;
    logic [CW-1:0]         col;
    c3z_pkg::word_bank_t   coefs, window;
    logic                  win_valid, mac_ready;

    assign acc = s_valid && s_ready;

    c3z_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .s_data    (s_data),
        .item      (item_in),
        .col       (col),
        .coefs     (coefs)
    );

    c3z_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc       (acc),
        .item_in   (item_in),
        .col_in    (col),
        .in_ready  (s_ready),
        .out_valid (win_valid),
        .out_ready (mac_ready),
        .item_out  (item_win),
        .window    (window)
    );

    c3z_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (win_valid),
        .in_ready (mac_ready),
        .item     (item_win),
        .window   (window),
        .coefs    (coefs),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- src/c3z_checker.sv -----
// ============================================================================
// c3z_checker
// Port-level checks on the convolution stream, bound to the top level.
// ============================================================================
module c3z_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input c3z_pkg::out_beat_t   m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // the input only blocks when the output is full and stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without output backpressure");

    // reset was already released before any result appears
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(aresetn))
        else $error("result appeared straight out of reset");

endmodule

bind conv3x3_zero_padded_stream c3z_checker u_c3z_checker (.*);

// ----- test/conv3x3_zero_padded_stream_tb.sv -----
// ============================================================================
// conv3x3_zero_padded_stream_tb
// Self-checking bench for the 3x3 zero-padded convolution stream. Each
// accepted input beat is run through a local model of the line stores, the
// window and the edge masks. Each output beat is compared against the oldest
// predicted sum. Frames of many sizes and kernels are driven, some of them
// reconfigured part way through, under random source and sink stalls.
// ============================================================================
module conv3x3_zero_padded_stream_tb;
    import c3z_pkg::*;

    localparam int unsigned MAX_W        = 1024;
    localparam int unsigned SETTLE       = 12;     // pipe is 5 deep
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned RANDOM_BEATS = 330;

    class conv_scoreboard;
        int unsigned           width_reg  = MAX_W;
        int unsigned           height_reg = 1;
        logic [CFG_DATA_W-1:0] coefs_lo   = '0;
        logic [CFG_DATA_W-1:0] coefs_hi   = '0;
        logic [SAMPLE_W-1:0]   coef_8     = '0;
        int                    line_older[MAX_W];
        int                    line_newer[MAX_W];
        int                    taps[KDIM][KDIM];
        int unsigned           in_col, in_row, out_col, out_row;
        out_beat_t             expected_sums[$];
        int                    errors, checked, frames;

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = val[10:0];
                REG_IMAGE_HEIGHT: height_reg = val[ROW_W-1:0];
                REG_COEFS_LOW:    coefs_lo   = val;
                REG_COEFS_HIGH:   coefs_hi   = val;
                REG_COEF_LAST:    coef_8     = val[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] coef_at(int k);
            if (k < 4) return coefs_lo[SAMPLE_W*k +: SAMPLE_W];
            if (k < 8) return coefs_hi[SAMPLE_W*(k-4) +: SAMPLE_W];
            return coef_8;
        endfunction

        function int unsigned pending();
            return expected_sums.size();
        endfunction

        // Advance the model by one accepted beat; returns 1 when that beat
        // closes the frame.
        function bit predict_conv(in_beat_t beat);
            int unsigned w, h;
            int          v;
            bit          emit, last;
            longint      acc;
            out_beat_t   res;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            if (in_col >= w) in_col = 0;
            if (out_col >= w) out_col = 0;
            v = 0;
            if (beat.opcode == OP_PIXEL && in_row < h) v = beat.sample;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            for (int a = 0; a < KDIM; a++) begin
                taps[a][0] = taps[a][1];
                taps[a][1] = taps[a][2];
            end
            taps[0][2] = line_older[in_col];
            taps[1][2] = line_newer[in_col];
            taps[2][2] = v;
            line_older[in_col] = line_newer[in_col];
            line_newer[in_col] = v;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                if (in_row < ROW_MAX) in_row++;
            end
            if (!emit) return 1'b0;

            acc = 0;
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            for (int a = 0; a < KDIM; a++) begin
                if (a == 0 && out_row == 0) continue;
                if (a == 2 && out_row + 1 >= h) continue;
                for (int b = 0; b < KDIM; b++) begin
                    if (b == 0 && out_col == 0) continue;
                    if (b == 2 && out_col + 1 >= w) continue;
                    acc += longint'(coef_at(8 - (3*a + b))) * longint'(taps[a][b]);
                end
            end
            res.conv_sum   = acc[SUM_W-1:0];
            res.frame_last = last;
            expected_sums.push_back(res);

            if (last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    if (out_row < ROW_MAX) out_row++;
                end
            end
            return last;
        endfunction

        function void check_output(out_beat_t got);
            out_beat_t want;
            if (expected_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual conv_sum %0d last %0b",
                         $time, got.conv_sum, got.frame_last);
                return;
            end
            want = expected_sums.pop_front();
            checked++;
            if (want.frame_last) frames++;
            if (got.conv_sum !== want.conv_sum) begin
                errors++;
                $display("%0t: conv_sum mismatch: expected %0d, actual %0d",
                         $time, want.conv_sum, got.conv_sum);
            end
            if (got.frame_last !== want.frame_last) begin
                errors++;
                $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                         $time, want.frame_last, got.frame_last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;

    conv_scoreboard        sb = new();

    int unsigned           src_idle_pct  = 0;
    int unsigned           snk_idle_pct  = 0;
    bit                    stall_request = 1'b0;
    int unsigned           beats_sent    = 0;
    int unsigned           reg_writes    = 0;
    logic [CFG_DATA_W-1:0] cur_lo, cur_hi;
    logic [SAMPLE_W-1:0]   cur_c8;

    conv3x3_zero_padded_stream #(.MAX_WIDTH(MAX_W)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic in_beat_t beat_of(logic op, logic signed [SAMPLE_W-1:0] s);
        in_beat_t b;
        b.opcode = op;
        b.sample = s;
        return b;
    endfunction

    function automatic void new_kernel();
        for (int i = 0; i < 4; i++) begin
            cur_lo[SAMPLE_W*i +: SAMPLE_W] = rand_sample();
            cur_hi[SAMPLE_W*i +: SAMPLE_W] = rand_sample();
        end
        cur_c8 = rand_sample();
    endfunction

    // zero is a legal write and is taken as one
    function automatic int unsigned pick_width();
        case ($urandom_range(0, 15))
            0:       return 0;
            1, 2:    return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_height();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(10, 20);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        reg_writes++;
    endtask

    task automatic set_config(input int unsigned w_raw, input int unsigned h_raw);
        cfg_write(REG_IMAGE_WIDTH,  CFG_DATA_W'(w_raw));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
        cfg_write(REG_COEFS_LOW,    cur_lo);
        cfg_write(REG_COEFS_HIGH,   cur_hi);
        cfg_write(REG_COEF_LAST,    CFG_DATA_W'(cur_c8));
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, let every predicted result out, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_beat(input in_beat_t beat, output bit last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        last = sb.predict_conv(beat);
        beats_sent++;
    endtask

    // image beats, with an occasional drain beat standing in for a zero pixel
    task automatic send_pixels(input int unsigned n);
        bit last;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(beat_of(OP_DRAIN, rand_sample()), last);
            else
                send_beat(beat_of(OP_PIXEL, rand_sample()), last);
        end
    endtask

    // tail beats until the flagged result; some tail beats are pixels
    task automatic finish_frame();
        bit last;
        do begin
            if ($urandom_range(0, 3) == 0)
                send_beat(beat_of(OP_PIXEL, rand_sample()), last);
            else
                send_beat(beat_of(OP_DRAIN, rand_sample()), last);
        end while (!last);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_output(m_data);
    end

    initial begin : sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned w, h, k, target;
        bit          last;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 20;
        snk_idle_pct = 20;

        // largest sum: every coefficient and every sample at -32768;
        // tail beats are pixels past the last row and must be ignored
        cur_lo = {4{16'h8000}};
        cur_hi = {4{16'h8000}};
        cur_c8 = 16'h8000;
        set_config(3, 3);
        repeat (9) send_beat(beat_of(OP_PIXEL, 16'sh8000), last);
        do send_beat(beat_of(OP_PIXEL, 16'sh7FFF), last); while (!last);

        // height written as zero; a drain beat inside the image
        wait_idle();
        new_kernel();
        set_config(2, 0);
        send_beat(beat_of(OP_PIXEL, 16'sh7FFF), last);
        send_beat(beat_of(OP_DRAIN, 16'sh8000), last);
        finish_frame();

        // tallest height, then cut below the rows already in
        wait_idle();
        new_kernel();
        set_config(3, 16'hFFFF);
        send_pixels(7);
        wait_idle();
        set_config(3, 2);
        finish_frame();

        // widest raw width, then narrowed below the column counter
        wait_idle();
        set_config(11'h7FF, 2);
        send_pixels(4);
        wait_idle();
        set_config(2, 2);
        finish_frame();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 30; snk_idle_pct = 83; end
                1:       begin src_idle_pct = 83; snk_idle_pct = 30; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            target = beats_sent + RANDOM_BEATS / 3;
            while (beats_sent < target) begin
                w = pick_width();
                h = pick_height();
                wait_idle();
                new_kernel();
                if (phase == 0 && beats_sent + RANDOM_BEATS / 3 == target) begin
                    // long sink hold while the source keeps pushing
                    w = 16;
                    h = 8;
                    stall_request = 1'b1;
                end
                set_config(w, h);
                w = (w == 0) ? 1 : w;
                h = (h == 0) ? 1 : h;
                if ($urandom_range(0, 5) == 0) begin
                    k = $urandom_range(1, w * h);
                    send_pixels(k);
                    wait_idle();
                    if ($urandom_range(0, 1) == 0) new_kernel();
                    set_config(pick_width(), $urandom_range(0, 4));
                end else begin
                    send_pixels(w * h);
                end
                finish_frame();
            end
        end

        // one full-width row to reach the last column, then narrowed
        wait_idle();
        new_kernel();
        set_config(MAX_W, 2);
        send_pixels(MAX_W);
        wait_idle();
        set_config(3, 2);
        finish_frame();

        wait_idle();
        $display("ran %0d input beats and checked %0d results over %0d frames",
                 beats_sent, sb.checked, sb.frames);
        $display("used %0d register writes, widths 1 to %0d, mid-frame resizes, long sink hold",
                 reg_writes, MAX_W);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
